>>> rtl/smv_pkg.sv
// ----------------------------------------------------------------------------
// smv_pkg
// shared widths, payload types and accumulator record for the streaming
// mean and variance core
// ----------------------------------------------------------------------------
package smv_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int COUNT_BITS  = 32;
	localparam int FRAC_BITS   = 16;

	localparam int SAMPLE_W = 16;
	localparam int MEAN_W   = 32;
	localparam int VAR_W    = 46;
	localparam int CNT_W    = 32;

	localparam int SUM_W  = SAMPLE_BITS + COUNT_BITS;
	localparam int SQ_W   = 2 * SAMPLE_BITS + COUNT_BITS;
	localparam int MUL_W  = COUNT_BITS + SQ_W;
	localparam int NUM_W  = MUL_W + FRAC_BITS;
	localparam int DIV_W  = 2 * COUNT_BITS;
	localparam int STEP_W = $clog2(NUM_W);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                last;
	} smv_in_t;

	typedef struct packed {
		logic [MEAN_W-1:0] mean_fixed;
		logic [VAR_W-1:0]  variance_fixed;
		logic [CNT_W-1:0]  item_count;
		logic              overflow;
	} smv_out_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] count;
		logic [SUM_W-1:0]      sum;
		logic [SQ_W-1:0]       sum_sq;
		logic                  overflow;
	} smv_acc_t;

endpackage

>>> rtl/smv_if.sv
// ----------------------------------------------------------------------------
// smv stream interfaces
// valid/ready channels for sample requests and finished set results
// ----------------------------------------------------------------------------
interface smv_in_if import smv_pkg::*;;
	logic    valid;
	logic    ready;
	smv_in_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface smv_out_if import smv_pkg::*;;
	logic     valid;
	logic     ready;
	smv_out_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> rtl/smv_front.sv
// ----------------------------------------------------------------------------
// smv_front
// accumulates count, sum and sum of squares one sample per cycle while the
// queue has room; the last request hands the finished set record to the queue
// ----------------------------------------------------------------------------
module smv_front import smv_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	smv_in_if.sink       samples,
	output logic         push,
	output smv_acc_t     push_data,
	input  logic         push_ready
);

	logic [COUNT_BITS-1:0]    count_q;
	logic [SUM_W-1:0]         sum_q;
	logic [SQ_W-1:0]          sum_sq_q;
	logic                     ovf_q;
	logic                     fire;
	logic                     saturated;
	logic [SAMPLE_BITS-1:0]   x;
	logic [2*SAMPLE_BITS-1:0] x_sq;
	smv_acc_t                 acc_next;

	assign samples.ready = push_ready;
	assign fire          = samples.valid && push_ready;
	assign saturated     = &count_q;
	assign x             = samples.data.sample[SAMPLE_BITS-1:0];
	assign x_sq          = x * x;

	always_comb begin
		if (saturated) begin
			acc_next.count    = count_q;
			acc_next.sum      = sum_q;
			acc_next.sum_sq   = sum_sq_q;
			acc_next.overflow = 1'b1;
		end else begin
			acc_next.count    = count_q + COUNT_BITS'(1);
			acc_next.sum      = sum_q + SUM_W'(x);
			acc_next.sum_sq   = sum_sq_q + SQ_W'(x_sq);
			acc_next.overflow = ovf_q;
		end
	end

	assign push      = fire && samples.data.last;
	assign push_data = acc_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			sum_q    <= '0;
			sum_sq_q <= '0;
			ovf_q    <= 1'b0;
		end else if (fire) begin
			if (samples.data.last) begin
				count_q  <= '0;
				sum_q    <= '0;
				sum_sq_q <= '0;
				ovf_q    <= 1'b0;
			end else begin
				count_q  <= acc_next.count;
				sum_q    <= acc_next.sum;
				sum_sq_q <= acc_next.sum_sq;
				ovf_q    <= acc_next.overflow;
			end
		end
	end

endmodule

>>> rtl/smv_queue.sv
// ----------------------------------------------------------------------------
// smv_queue
// short queue of finished set records between accumulator and divider
// ----------------------------------------------------------------------------
module smv_queue import smv_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  smv_acc_t push_data,
	output logic     push_ready,
	input  logic     pop,
	output logic     head_valid,
	output smv_acc_t head
);

	smv_acc_t          entries [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = fill_q != QCNT_W'(QUEUE_DEPTH);
	assign head_valid = fill_q != '0;
	assign head       = entries[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 :
					wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 :
					rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - QCNT_W'(1);
			end
		end
	end

endmodule

>>> rtl/smv_back.sv
// ----------------------------------------------------------------------------
// smv_back
// shift-add multiplier and restoring divider sequencer that turns a set
// record into mean and population variance, with a result output register
// ----------------------------------------------------------------------------
module smv_back import smv_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     head_valid,
	input  smv_acc_t head,
	output logic     pop,
	smv_out_if.source results
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_NQ,
		ST_MUL_SS,
		ST_MUL_NN,
		ST_DIV_MEAN,
		ST_DIV_VAR,
		ST_EMIT
	} state_t;

	state_t                state_q;
	logic [COUNT_BITS-1:0] n_q;
	logic [SUM_W-1:0]      s_q;
	logic                  ovf_q;
	logic [MUL_W-1:0]      acc_q;
	logic [MUL_W-1:0]      mcand_q;
	logic [SUM_W-1:0]      mplier_q;
	logic [STEP_W-1:0]     step_q;
	logic [MUL_W-1:0]      prod_nq_q;
	logic [NUM_W-1:0]      var_num_q;
	logic [DIV_W-1:0]      nsq_q;
	logic [NUM_W-1:0]      num_q;
	logic [DIV_W-1:0]      rem_q;
	logic [DIV_W-1:0]      div_q;
	logic [VAR_W-1:0]      quo_q;
	logic [MEAN_W-1:0]     mean_q;
	logic [VAR_W-1:0]      var_q;
	logic                  out_valid_q;
	smv_out_t              out_data_q;

	logic [MUL_W-1:0]  acc_step;
	logic [DIV_W:0]    div_r;
	logic [DIV_W:0]    div_sub;
	logic              div_ge;
	logic [DIV_W-1:0]  rem_step;
	logic [VAR_W-1:0]  quo_step;
	logic [MUL_W-1:0]  diff;
	logic              out_free;
	logic              emit;

	assign acc_step = mplier_q[0] ? acc_q + mcand_q : acc_q;
	assign div_r    = {rem_q, num_q[NUM_W-1]};
	assign div_sub  = div_r - {1'b0, div_q};
	assign div_ge   = div_r >= {1'b0, div_q};
	assign rem_step = div_ge ? div_sub[DIV_W-1:0] : div_r[DIV_W-1:0];
	assign quo_step = {quo_q[VAR_W-2:0], div_ge};
	assign diff     = prod_nq_q - acc_step;
	assign out_free = !out_valid_q || results.ready;
	assign emit     = (state_q == ST_EMIT) && out_free;

	assign pop           = (state_q == ST_IDLE) && head_valid;
	assign results.valid = out_valid_q;
	assign results.data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= '0;
			s_q         <= '0;
			ovf_q       <= 1'b0;
			acc_q       <= '0;
			mcand_q     <= '0;
			mplier_q    <= '0;
			step_q      <= '0;
			prod_nq_q   <= '0;
			var_num_q   <= '0;
			nsq_q       <= '0;
			num_q       <= '0;
			rem_q       <= '0;
			div_q       <= '0;
			quo_q       <= '0;
			mean_q      <= '0;
			var_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (head_valid) begin
						n_q      <= head.count;
						s_q      <= head.sum;
						ovf_q    <= head.overflow;
						acc_q    <= '0;
						mcand_q  <= MUL_W'(head.sum_sq);
						mplier_q <= SUM_W'(head.count);
						step_q   <= '0;
						state_q  <= ST_MUL_NQ;
					end
				end
				ST_MUL_NQ: begin
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					acc_q    <= acc_step;
					step_q   <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(COUNT_BITS - 1)) begin
						prod_nq_q <= acc_step;
						acc_q     <= '0;
						mcand_q   <= MUL_W'(s_q);
						mplier_q  <= s_q;
						step_q    <= '0;
						state_q   <= ST_MUL_SS;
					end
				end
				ST_MUL_SS: begin
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					acc_q    <= acc_step;
					step_q   <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(SUM_W - 1)) begin
						if (prod_nq_q >= acc_step) begin
							var_num_q <= NUM_W'(diff) << FRAC_BITS;
						end else begin
							var_num_q <= '0;
						end
						acc_q    <= '0;
						mcand_q  <= MUL_W'(n_q);
						mplier_q <= SUM_W'(n_q);
						step_q   <= '0;
						state_q  <= ST_MUL_NN;
					end
				end
				ST_MUL_NN: begin
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					acc_q    <= acc_step;
					step_q   <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(COUNT_BITS - 1)) begin
						nsq_q   <= acc_step[DIV_W-1:0];
						num_q   <= NUM_W'(s_q) << (NUM_W - SUM_W);
						rem_q   <= '0;
						div_q   <= DIV_W'(n_q);
						quo_q   <= '0;
						step_q  <= '0;
						state_q <= ST_DIV_MEAN;
					end
				end
				ST_DIV_MEAN: begin
					num_q  <= num_q << 1;
					rem_q  <= rem_step;
					quo_q  <= quo_step;
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(SUM_W + FRAC_BITS - 1)) begin
						mean_q  <= quo_step[MEAN_W-1:0];
						num_q   <= var_num_q;
						rem_q   <= '0;
						div_q   <= nsq_q;
						quo_q   <= '0;
						step_q  <= '0;
						state_q <= ST_DIV_VAR;
					end
				end
				ST_DIV_VAR: begin
					num_q  <= num_q << 1;
					rem_q  <= rem_step;
					quo_q  <= quo_step;
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(NUM_W - 1)) begin
						var_q   <= quo_step;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit) begin
						out_data_q.mean_fixed      <= mean_q;
						out_data_q.variance_fixed  <= var_q;
						out_data_q.item_count      <= CNT_W'(n_q);
						out_data_q.overflow        <= ovf_q;
						state_q                    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/streaming_mean_variance_core.sv
// ----------------------------------------------------------------------------
// streaming_mean_variance_core
// one-pass mean and population variance over sets of unsigned samples
// throughput: one sample per cycle while the set queue has room; the back end
// works through each set with the bit-serial multiplier and divider before it
// takes the next one from the queue, where two sets may wait
// reset: arst_n clears accumulators, queue and sequencer at once, no sweep
// ----------------------------------------------------------------------------
module streaming_mean_variance_core import smv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	smv_in_if.sink    samples,
	smv_out_if.source results
);

	logic     push;
	logic     push_ready;
	smv_acc_t push_data;
	logic     pop;
	logic     head_valid;
	smv_acc_t head;

	smv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	smv_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	smv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.results    (results)
	);

endmodule

>>> bench/tb_streaming_mean_variance_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_streaming_mean_variance_core
// drives sets of unsigned samples into the core through a queue-fed driver,
// predicts count, mean and population variance per set with exact wide
// integer arithmetic, and checks every result against the oldest prediction
// under random idling on both channels and one long result back-pressure
// ----------------------------------------------------------------------------
module tb_streaming_mean_variance_core;
	import smv_pkg::*;

	localparam int RANDOM_REQS  = 1750;
	localparam int TAIL_REQS    = 200;
	localparam int DRAIN_CYCLES = 800;
	localparam int LONG_HOLD    = 2000;
	localparam int HOLD_AT      = 300;
	localparam int MAX_PRINTS   = 40;

	bit   clk;
	logic arst_n;

	smv_in_if  sample_ch ();
	smv_out_if result_ch ();

	streaming_mean_variance_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (sample_ch),
		.results (result_ch)
	);

	smv_in_t  pending_reqs[$];
	smv_out_t expected_stats[$];

	logic [COUNT_BITS-1:0] acc_count  = '0;
	logic [SUM_W-1:0]      acc_sum    = '0;
	logic [63:0]           acc_sumsq  = '0;
	logic                  acc_ovf    = 1'b0;

	int total_reqs     = 0;
	int accepted_reqs  = 0;
	int seen_results   = 0;
	int errors         = 0;
	bit req_taken      = 1'b0;
	bit tail_phase     = 1'b0;
	int drv_idle_left  = 0;
	int drv_odds       = 0;
	int rcv_stall_left = 0;
	int rcv_odds       = 0;
	int hold_left      = 0;
	bit hold_done      = 1'b0;

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("timeout with %0d results still awaited", expected_stats.size());
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
	endtask

	task automatic add_req(input logic [SAMPLE_W-1:0] value, input logic mark_last);
		smv_in_t req;
		req.sample = value;
		req.last   = mark_last;
		pending_reqs.push_back(req);
	endtask

	// accumulates one sample and, on the final sample of a set, yields its statistics
	function automatic bit fold_sample(input smv_in_t req, output smv_out_t stats);
		logic [SAMPLE_BITS-1:0] x;
		logic [127:0]           n;
		logic [127:0]           lhs;
		logic [127:0]           rhs;
		logic [127:0]           quo;
		logic [63:0]            mean_q;
		x = req.sample[SAMPLE_BITS-1:0];
		stats = '0;
		if (acc_count == {COUNT_BITS{1'b1}}) begin
			acc_ovf = 1'b1;
		end else begin
			acc_count = acc_count + 1'b1;
			acc_sum   = acc_sum + x;
			acc_sumsq = acc_sumsq + 64'(x) * 64'(x);
		end
		if (!req.last)
			return 1'b0;
		n = 128'(acc_count);
		if (n == 0)
			n = 128'd1;
		mean_q = (64'(acc_sum) << FRAC_BITS) / n[63:0];
		lhs = n * 128'(acc_sumsq);
		rhs = 128'(acc_sum) * 128'(acc_sum);
		if (lhs < rhs)
			quo = '0;
		else
			quo = ((lhs - rhs) << FRAC_BITS) / (n * n);
		stats.mean_fixed     = mean_q[MEAN_W-1:0];
		stats.variance_fixed = quo[VAR_W-1:0];
		stats.item_count     = acc_count;
		stats.overflow       = acc_ovf;
		acc_count = '0;
		acc_sum   = '0;
		acc_sumsq = '0;
		acc_ovf   = 1'b0;
		return 1'b1;
	endfunction

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
		end else begin
			if ($urandom_range(0, 99) == 0) begin
				case ($urandom_range(0, 2))
					0: drv_odds = 0;
					1: drv_odds = 3;
					default: drv_odds = 10;
				endcase
			end
			if (sample_ch.valid && !req_taken) begin
				// held until accepted
			end else if (drv_idle_left > 0) begin
				drv_idle_left--;
				sample_ch.valid <= 1'b0;
			end else if (pending_reqs.size() == 0) begin
				sample_ch.valid <= 1'b0;
			end else if (!tail_phase && drv_odds != 0 && $urandom_range(1, drv_odds) == 1) begin
				drv_idle_left = $urandom_range(1, 6) - 1;
				sample_ch.valid <= 1'b0;
			end else begin
				sample_ch.data  <= pending_reqs.pop_front();
				sample_ch.valid <= 1'b1;
			end
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if ($urandom_range(0, 39) == 0) begin
				case ($urandom_range(0, 2))
					0: rcv_odds = 0;
					1: rcv_odds = 2;
					default: rcv_odds = 6;
				endcase
			end
			if (!hold_done && accepted_reqs >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (rcv_stall_left > 0) begin
				rcv_stall_left--;
				result_ch.ready <= 1'b0;
			end else if (!tail_phase && rcv_odds != 0 && $urandom_range(1, rcv_odds) == 1) begin
				rcv_stall_left = $urandom_range(1, 6) - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		smv_out_t stats;
		smv_out_t want;
		if (!arst_n) begin
			req_taken = 1'b0;
		end else begin
			req_taken = sample_ch.valid && sample_ch.ready;
			if (req_taken) begin
				accepted_reqs++;
				tail_phase = (accepted_reqs + TAIL_REQS >= total_reqs);
				if (fold_sample(sample_ch.data, stats))
					expected_stats.push_back(stats);
			end
			if (result_ch.valid && result_ch.ready) begin
				seen_results++;
				if (expected_stats.size() == 0) begin
					report_mismatch("unexpected result", 64'(result_ch.data.item_count), 64'd0);
				end else begin
					want = expected_stats.pop_front();
					if (result_ch.data.mean_fixed !== want.mean_fixed)
						report_mismatch("mean_fixed", 64'(result_ch.data.mean_fixed),
							64'(want.mean_fixed));
					if (result_ch.data.variance_fixed !== want.variance_fixed)
						report_mismatch("variance_fixed", 64'(result_ch.data.variance_fixed),
							64'(want.variance_fixed));
					if (result_ch.data.item_count !== want.item_count)
						report_mismatch("item_count", 64'(result_ch.data.item_count),
							64'(want.item_count));
					if (result_ch.data.overflow !== want.overflow)
						report_mismatch("overflow", 64'(result_ch.data.overflow),
							64'(want.overflow));
				end
			end
		end
	end

	initial begin
		int                  made;
		int                  len;
		int                  mode;
		int                  pick;
		logic [SAMPLE_W-1:0] base;
		logic [SAMPLE_W-1:0] value;

		arst_n          = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.data  = '0;
		result_ch.ready = 1'b0;

		// single-sample sets at both extremes
		add_req(16'h0000, 1'b1);
		add_req(16'hFFFF, 1'b1);
		// constant full-scale set, zero variance
		add_req(16'hFFFF, 1'b0);
		add_req(16'hFFFF, 1'b0);
		add_req(16'hFFFF, 1'b1);
		// widest spread
		add_req(16'h0000, 1'b0);
		add_req(16'hFFFF, 1'b1);
		for (int i = 0; i < 8; i++)
			add_req(i[0] ? 16'hFFFF : 16'h0000, i == 7);
		// mean with a truncated fraction
		add_req(16'd1, 1'b0);
		add_req(16'd2, 1'b0);
		add_req(16'd4, 1'b1);
		// alternating bit patterns
		add_req(16'h5555, 1'b0);
		add_req(16'hAAAA, 1'b1);

		made = 0;
		while (made < RANDOM_REQS) begin
			case ($urandom_range(0, 29))
				0: len = $urandom_range(256, 600);
				1, 2, 3: len = 1;
				default: len = $urandom_range(2, 24);
			endcase
			if (len > RANDOM_REQS - made)
				len = RANDOM_REQS - made;
			mode = $urandom_range(0, 3);
			base = 16'($urandom);
			for (int i = 0; i < len; i++) begin
				case (mode)
					0: begin
						pick  = $urandom_range(0, 7);
						value = (pick == 0) ? 16'h0000 :
							(pick == 1) ? 16'hFFFF : 16'($urandom);
					end
					1: value = base;
					2: value = base ^ 16'($urandom_range(0, 3));
					default: value = 16'($urandom);
				endcase
				add_req(value, i == len - 1);
			end
			made += len;
		end
		total_reqs = pending_reqs.size();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (accepted_reqs != total_reqs)
			@(posedge clk);
		while (expected_stats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> streaming_mean_variance_core.f
rtl/smv_pkg.sv
rtl/smv_if.sv
rtl/smv_front.sv
rtl/smv_queue.sv
rtl/smv_back.sv
rtl/streaming_mean_variance_core.sv
bench/tb_streaming_mean_variance_core.sv
